### src/a2s_pkg.sv
// ----------------------------------------------------------------------------
// a2s_pkg
// Shared types and codes for the address to symbol lookup block.
// ----------------------------------------------------------------------------
package a2s_pkg;

  localparam int DEFAULT_MAX_SYMBOLS = 256;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  localparam logic [1:0] STATUS_NONE     = 2'd0;
  localparam logic [1:0] STATUS_EXACT    = 2'd1;
  localparam logic [1:0] STATUS_FALLBACK = 2'd2;

  localparam logic REG_ENTRY_COUNT = 1'b0;
  localparam logic REG_STRING_BASE = 1'b1;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] size;
    logic [31:0] name_off;
  } a2s_entry_t;

  typedef struct packed {
    logic wr_entry;
    logic start;
    logic scan;
    logic out_load;
  } a2s_cmd_t;

  typedef struct packed {
    logic hit;
    logic scan_done;
    logic out_free;
  } a2s_stat_t;

endpackage

### src/a2s_ctrl.sv
// ----------------------------------------------------------------------------
// a2s_ctrl
// Controller: accepts transactions, sequences the table scan and the
// hand-over of a result to the output register.
// ----------------------------------------------------------------------------
module a2s_ctrl
  import a2s_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_command,
  output logic      in_stall,
  input  a2s_stat_t stat,
  output a2s_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       in_acc;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    cmd.wr_entry = in_acc && (in_command == CMD_WRITE);
    cmd.start    = in_acc && (in_command == CMD_LOOKUP);
    cmd.scan     = (state_r == ST_SCAN);
    cmd.out_load = (state_r == ST_FIN) && stat.out_free;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.start) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (stat.hit || stat.scan_done) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (stat.out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_start_scans: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> state_r == ST_SCAN)
    else $error("lookup did not enter scan");

  a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && (stat.hit || stat.scan_done)) |=> state_r == ST_FIN)
    else $error("scan end did not reach hand-over");

  a_fin_leaves: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && stat.out_free) |=> state_r == ST_IDLE)
    else $error("result hand-over did not return to idle");

endmodule

### src/a2s_datapath.sv
// ----------------------------------------------------------------------------
// a2s_datapath
// Symbol table memory, scan counter, range and nearest-start compare, result
// and output registers, configuration registers.
// ----------------------------------------------------------------------------
module a2s_datapath
  import a2s_pkg::*;
#(
  parameter int MAX_SYMBOLS = DEFAULT_MAX_SYMBOLS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  a2s_cmd_t    cmd,
  output a2s_stat_t   stat,
  input  logic [7:0]  in_entry_index,
  input  logic [31:0] in_entry_start,
  input  logic [31:0] in_entry_size,
  input  logic [31:0] in_entry_name_offset,
  input  logic [31:0] in_lookup_address,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_match_status,
  output logic [31:0] out_name_address,
  output logic [31:0] out_symbol_start_out
);

  localparam int IW = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
  localparam int CW = $clog2(MAX_SYMBOLS + 1);

  a2s_entry_t  mem [MAX_SYMBOLS];
  a2s_entry_t  rd_data_r;
  a2s_entry_t  wr_data;
  logic        slot_ok;

  logic [8:0]  count_r;
  logic [31:0] base_r;
  logic [CW-1:0] cnt_sat;

  logic [CW-1:0] idx_r;
  logic        ev_vld_r;
  logic [31:0] addr_r;
  logic [31:0] best_start_r;
  logic [31:0] best_name_r;

  logic [32:0] end33;
  logic        hit;
  logic        better;
  logic        scan_done;

  logic [1:0]  res_status_r;
  logic [31:0] res_name_r;
  logic [31:0] res_start_r;
  logic        out_valid_r;
  logic [1:0]  out_status_r;
  logic [31:0] out_name_r;
  logic [31:0] out_start_r;

  assign wr_data = '{start: in_entry_start, size: in_entry_size,
                     name_off: in_entry_name_offset};
  assign slot_ok = 32'(in_entry_index) < 32'(MAX_SYMBOLS);

  always_ff @(posedge clk) begin
    if (cmd.wr_entry && slot_ok) mem[IW'(in_entry_index)] <= wr_data;
    rd_data_r <= mem[idx_r[IW-1:0]];
  end

  assign cnt_sat = (32'(count_r) > 32'(MAX_SYMBOLS)) ? CW'(MAX_SYMBOLS) : CW'(count_r);

  assign end33     = {1'b0, rd_data_r.start} + {1'b0, rd_data_r.size};
  assign hit       = ev_vld_r && (addr_r >= rd_data_r.start) && ({1'b0, addr_r} < end33);
  assign better    = ev_vld_r && (rd_data_r.start > best_start_r) &&
                     (rd_data_r.start <= addr_r);
  assign scan_done = (idx_r == cnt_sat) && !ev_vld_r;

  always_comb begin
    stat.hit       = hit;
    stat.scan_done = scan_done;
    stat.out_free  = !out_valid_r || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      base_r      <= '0;
      idx_r       <= '0;
      ev_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ENTRY_COUNT: count_r <= cfg_wdata[8:0];
          REG_STRING_BASE: base_r  <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.start) begin
        idx_r    <= '0;
        ev_vld_r <= 1'b0;
      end else if (cmd.scan) begin
        if (!hit && (idx_r != cnt_sat)) begin
          idx_r    <= idx_r + CW'(1);
          ev_vld_r <= 1'b1;
        end else begin
          ev_vld_r <= 1'b0;
        end
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      addr_r       <= in_lookup_address;
      best_start_r <= '0;
    end else if (cmd.scan && better) begin
      best_start_r <= rd_data_r.start;
      best_name_r  <= rd_data_r.name_off;
    end
    if (cmd.scan && hit) begin
      res_status_r <= STATUS_EXACT;
      res_name_r   <= base_r + rd_data_r.name_off;
      res_start_r  <= rd_data_r.start;
    end else if (cmd.scan && scan_done) begin
      if (best_start_r != '0) begin
        res_status_r <= STATUS_FALLBACK;
        res_name_r   <= base_r + best_name_r;
        res_start_r  <= best_start_r;
      end else begin
        res_status_r <= STATUS_NONE;
        res_name_r   <= '0;
        res_start_r  <= '0;
      end
    end
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_name_r   <= res_name_r;
      out_start_r  <= res_start_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_match_status     = out_status_r;
  assign out_name_address     = out_name_r;
  assign out_symbol_start_out = out_start_r;

  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> (idx_r == '0) && !ev_vld_r)
    else $error("scan not restarted");

  a_eval_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    ev_vld_r |-> (idx_r != '0) && (idx_r <= cnt_sat))
    else $error("entry evaluated without a read");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == STATUS_NONE) |-> (out_name_r == '0) && (out_start_r == '0))
    else $error("no-symbol result carries data");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !out_valid_r || !out_stall)
    else $error("output overwritten while stalled");

endmodule

### src/address_to_symbol_lookup.sv
// ----------------------------------------------------------------------------
// address_to_symbol_lookup
// Resolves an address to a symbol from a loaded table of entries.
// ----------------------------------------------------------------------------
// Usage:
//   Input transactions (in_valid/in_stall) either load one table entry
//   (command write) or resolve an address (command lookup). Loads give no
//   result. A lookup gives exactly one result transaction on
//   out_valid/out_stall: status, name address and symbol start. A lookup
//   scans the table memory one entry per cycle through a single registered
//   read port, stopping early on an exact hit. in_stall stays high until the
//   result is loaded. The next transaction is taken while a result still
//   sits in the output register; a further result waits until it is taken,
//   holding in_stall high.
//   cfg_we/cfg_index/cfg_wdata write entry_count and string_base; write them
//   only while no lookup is in progress.
//   Reset clears the controller, the output valid and both registers. Table
//   entries are undefined until loaded; no clearing pass is made.
// ----------------------------------------------------------------------------
module address_to_symbol_lookup
  import a2s_pkg::*;
#(
  parameter int MAX_SYMBOLS = DEFAULT_MAX_SYMBOLS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [7:0]  in_entry_index,
  input  logic [31:0] in_entry_start,
  input  logic [31:0] in_entry_size,
  input  logic [31:0] in_entry_name_offset,
  input  logic [31:0] in_lookup_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_match_status,
  output logic [31:0] out_name_address,
  output logic [31:0] out_symbol_start_out,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata
);

  a2s_cmd_t  cmd;
  a2s_stat_t stat;

  a2s_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_stall   (in_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  a2s_datapath #(
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_datapath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .stat                 (stat),
    .in_entry_index       (in_entry_index),
    .in_entry_start       (in_entry_start),
    .in_entry_size        (in_entry_size),
    .in_entry_name_offset (in_entry_name_offset),
    .in_lookup_address    (in_lookup_address),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_match_status     (out_match_status),
    .out_name_address     (out_name_address),
    .out_symbol_start_out (out_symbol_start_out)
  );

endmodule

### sim/address_to_symbol_lookup_test.sv
// ----------------------------------------------------------------------------
// address_to_symbol_lookup_test
// Self-checking bench for the address to symbol lookup block. Loads symbol
// tables, resolves addresses under a range of entry counts and string bases,
// and checks every result transaction against a behavioural table scan.
// Sender bursts and receiver stalls are randomised throughout.
// ----------------------------------------------------------------------------
module address_to_symbol_lookup_test;
  import a2s_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int LOAD_SETTLE    = 8;
  localparam int SCAN_SETTLE    = 300;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] name_addr;
    logic [31:0] sym_start;
  } symbol_result_t;

  class symbol_scoreboard;
    a2s_entry_t     symbols[DEFAULT_MAX_SYMBOLS];
    logic [8:0]     entry_count;
    logic [31:0]    string_base;
    symbol_result_t pending_lookups[$];
    int             errors;

    function new();
      entry_count = '0;
      string_base = '0;
      errors      = 0;
    endfunction

    function void write_register(logic idx, logic [31:0] data);
      if (idx == REG_ENTRY_COUNT) begin
        entry_count = data[8:0];
      end else begin
        string_base = data;
      end
    endfunction

    // first containing entry wins; else greatest nonzero start <= address
    function symbol_result_t resolve_address(logic [31:0] addr);
      int             lim;
      int             best_idx;
      logic [31:0]    best_start;
      logic [32:0]    range_end;
      symbol_result_t res;
      lim        = (entry_count > DEFAULT_MAX_SYMBOLS) ? DEFAULT_MAX_SYMBOLS : entry_count;
      best_idx   = -1;
      best_start = '0;
      for (int i = 0; i < lim; i++) begin
        range_end = {1'b0, symbols[i].start} + {1'b0, symbols[i].size};
        if (addr >= symbols[i].start && {1'b0, addr} < range_end) begin
          res.status    = STATUS_EXACT;
          res.name_addr = string_base + symbols[i].name_off;
          res.sym_start = symbols[i].start;
          return res;
        end
        if (symbols[i].start > best_start && symbols[i].start <= addr) begin
          best_start = symbols[i].start;
          best_idx   = i;
        end
      end
      if (best_idx >= 0) begin
        res.status    = STATUS_FALLBACK;
        res.name_addr = string_base + symbols[best_idx].name_off;
        res.sym_start = best_start;
      end else begin
        res = '{STATUS_NONE, 32'd0, 32'd0};
      end
      return res;
    endfunction

    function void note_transaction(logic cmd, logic [7:0] idx, a2s_entry_t ent,
                                   logic [31:0] addr);
      if (cmd == CMD_WRITE) begin
        if (idx < DEFAULT_MAX_SYMBOLS) symbols[idx] = ent;
      end else begin
        pending_lookups.push_back(resolve_address(addr));
      end
    endfunction

    function void check_result(symbol_result_t got);
      symbol_result_t exp;
      if (pending_lookups.size() == 0) begin
        $error("unexpected result transaction: status %0d", got.status);
        errors++;
        return;
      end
      exp = pending_lookups.pop_front();
      if (got.status !== exp.status) begin
        $error("match_status: expected %0d, actual %0d", exp.status, got.status);
        errors++;
      end
      if (got.name_addr !== exp.name_addr) begin
        $error("name_address: expected %h, actual %h", exp.name_addr, got.name_addr);
        errors++;
      end
      if (got.sym_start !== exp.sym_start) begin
        $error("symbol_start_out: expected %h, actual %h", exp.sym_start, got.sym_start);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_command = CMD_WRITE;
  logic [7:0]  in_entry_index = '0;
  logic [31:0] in_entry_start = '0;
  logic [31:0] in_entry_size = '0;
  logic [31:0] in_entry_name_offset = '0;
  logic [31:0] in_lookup_address = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_match_status;
  logic [31:0] out_name_address;
  logic [31:0] out_symbol_start_out;
  logic        cfg_we = 1'b0;
  logic        cfg_index = REG_ENTRY_COUNT;
  logic [31:0] cfg_wdata = '0;

  symbol_scoreboard sb;
  int burst_left = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  int stall_mode = 0;
  logic [3:0] stall_phase = '0;

  address_to_symbol_lookup uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_command           (in_command),
    .in_entry_index       (in_entry_index),
    .in_entry_start       (in_entry_start),
    .in_entry_size        (in_entry_size),
    .in_entry_name_offset (in_entry_name_offset),
    .in_lookup_address    (in_lookup_address),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_match_status     (out_match_status),
    .out_name_address     (out_name_address),
    .out_symbol_start_out (out_symbol_start_out),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // transaction monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) sb.write_register(cfg_index, cfg_wdata);
      if (in_valid && !in_stall) begin
        sb.note_transaction(in_command, in_entry_index,
                            '{in_entry_start, in_entry_size, in_entry_name_offset},
                            in_lookup_address);
      end
      if (out_valid && !out_stall) begin
        sb.check_result('{out_match_status, out_name_address, out_symbol_start_out});
      end
    end
  end

  // receiver back-pressure: free, random, heavy random, periodic
  always @(negedge clk) begin
    stall_phase <= stall_phase + 4'd1;
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(32, 256);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= 1'($urandom_range(0, 1));
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (stall_phase < 4'd12);
    endcase
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // entered and left just after a falling edge
  task automatic send_transaction(logic cmd, logic [7:0] idx, a2s_entry_t ent,
                                  logic [31:0] addr);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end
    in_valid             <= 1'b1;
    in_command           <= cmd;
    in_entry_index       <= idx;
    in_entry_start       <= ent.start;
    in_entry_size        <= ent.size;
    in_entry_name_offset <= ent.name_off;
    in_lookup_address    <= addr;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    burst_left--;
  endtask

  task automatic load_symbol(logic [7:0] idx, a2s_entry_t ent);
    send_transaction(CMD_WRITE, idx, ent, $urandom);
  endtask

  task automatic lookup(logic [31:0] addr);
    send_transaction(CMD_LOOKUP, 8'($urandom), '{$urandom, $urandom, $urandom}, addr);
  endtask

  task automatic drain_results(int settle);
    in_valid <= 1'b0;
    while (sb.pending_lookups.size() != 0) @(posedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic configure(logic [8:0] count, logic [31:0] base);
    cfg_we    <= 1'b1;
    cfg_index <= REG_ENTRY_COUNT;
    cfg_wdata <= {23'd0, count};
    @(negedge clk);
    cfg_index <= REG_STRING_BASE;
    cfg_wdata <= base;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cfg_wdata <= $urandom;
  endtask

  function automatic a2s_entry_t random_symbol();
    a2s_entry_t ent;
    case ($urandom_range(0, 7))
      0:       ent.start = '0;
      1:       ent.start = $urandom;
      2:       ent.start = 32'hFFFF_FF00 | $urandom_range(0, 255);
      default: ent.start = $urandom_range(0, 'h10000);
    endcase
    case ($urandom_range(0, 15))
      0, 1:    ent.size = '0;
      2, 3:    ent.size = $urandom;
      4:       ent.size = '1;
      default: ent.size = $urandom_range(1, 'h400);
    endcase
    ent.name_off = $urandom;
    return ent;
  endfunction

  // addresses aimed at the scanned part of the table
  function automatic logic [31:0] pick_address(int lim);
    a2s_entry_t ent;
    if (lim == 0) return $urandom;
    ent = sb.symbols[$urandom_range(0, lim - 1)];
    case ($urandom_range(0, 5))
      0: return ent.start + ((ent.size == 0) ? 32'd0 : $urandom % ent.size);
      1: return ent.start - 32'd1;
      2: return ent.start + ent.size;
      3: return ent.start + ent.size - 32'd1;
      4: return $urandom_range(0, 'h11000);
      default: return $urandom;
    endcase
  endfunction

  task automatic run_phase(logic [8:0] count, logic [31:0] base, int n_items);
    int lim;
    drain_results(LOAD_SETTLE);
    configure(count, base);
    lim = (count > DEFAULT_MAX_SYMBOLS) ? DEFAULT_MAX_SYMBOLS : count;
    repeat (n_items) begin
      if ($urandom_range(0, 4) == 0) begin
        load_symbol(8'($urandom_range(0, 255)), random_symbol());
      end else begin
        lookup(pick_address(lim));
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty table
    configure(9'd0, 32'd0);
    lookup(32'h0000_0000);
    lookup(32'hFFFF_FFFF);

    // overlaps, zero sizes, tied starts, top-of-memory range
    load_symbol(8'd0, '{32'h0000_0000, 32'h0000_0000, 32'h0000_0011});
    load_symbol(8'd1, '{32'h0000_1000, 32'h0000_0100, 32'h0000_0100});
    load_symbol(8'd2, '{32'h0000_1080, 32'h0000_0010, 32'h0000_0200});
    load_symbol(8'd3, '{32'h0000_2000, 32'h0000_0000, 32'h0000_0300});
    load_symbol(8'd4, '{32'h0000_2000, 32'h0000_0040, 32'h0000_0400});
    load_symbol(8'd5, '{32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
    load_symbol(8'd6, '{32'h0000_5000, 32'h0000_0020, 32'h0000_0600});
    load_symbol(8'd7, '{32'h0000_5000, 32'h0000_0010, 32'h0000_0700});
    drain_results(LOAD_SETTLE);
    configure(9'd8, 32'hFFFF_FF00);
    lookup(32'h0000_0000);
    lookup(32'h0000_0005);
    lookup(32'h0000_0FFF);
    lookup(32'h0000_1000);
    lookup(32'h0000_10FF);
    lookup(32'h0000_1088);
    lookup(32'h0000_1100);
    lookup(32'h0000_2000);
    lookup(32'h0000_3000);
    lookup(32'h0000_5030);
    lookup(32'hFFFF_FFFF);
    lookup(32'hFFFF_FFEF);

    // load every slot so any entry count is legal from here on
    for (int i = 0; i < DEFAULT_MAX_SYMBOLS; i++) load_symbol(i[7:0], random_symbol());

    run_phase(9'd511, $urandom, 20);
    run_phase(9'd1, 32'd0, 20);
    run_phase(9'd256, 32'hFFFF_FFFF, 25);
    run_phase(9'($urandom_range(2, 40)), $urandom, 35);
    run_phase(9'd257, $urandom, 20);
    run_phase(9'd0, $urandom, 10);
    run_phase(9'($urandom_range(1, 16)), $urandom, 40);
    run_phase(9'($urandom_range(100, 255)), $urandom, 30);
    run_phase(9'($urandom_range(258, 510)), $urandom, 20);
    run_phase(9'($urandom_range(2, 12)), $urandom, 52);

    drain_results(SCAN_SETTLE);
    if (sb.pending_lookups.size() != 0) begin
      $error("%0d lookups never answered", sb.pending_lookups.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
